[src/fsbc_pkg.sv]
`timescale 1ns / 1ps
// fsbc_pkg: shared types and constants of the filter sense batch classifier
// used by every module under src; depends on nothing
package fsbc_pkg;

	// samples in a well-formed batch
	localparam int unsigned SAMPLES = 16;

	// depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int unsigned MV_W    = 12;
	localparam int unsigned RAW_W   = 12;
	localparam int unsigned LIMIT_W = 13;
	localparam int unsigned SUM_W   = 20;
	localparam int unsigned COUNT_W = 9;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam int unsigned PADDR_W = 5;
	localparam int unsigned PDATA_W = 32;

	typedef enum logic [1:0] {
		CLASS_INVALID = 2'd0,
		CLASS_A       = 2'd1,
		CLASS_B       = 2'd2,
		CLASS_MISSING = 2'd3
	} class_t;

	typedef enum logic [2:0] {
		REG_BAND_A_MIN  = 3'd0,
		REG_BAND_A_MAX  = 3'd1,
		REG_BAND_B_MIN  = 3'd2,
		REG_BAND_B_MAX  = 3'd3,
		REG_MISSING_MIN = 3'd4,
		REG_RAW_LIMIT   = 3'd5,
		REG_SPREAD_LIM  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [MV_W-1:0]    band_a_min_mv;
		logic [MV_W-1:0]    band_a_max_mv;
		logic [MV_W-1:0]    band_b_min_mv;
		logic [MV_W-1:0]    band_b_max_mv;
		logic [MV_W-1:0]    missing_min_mv;
		logic [LIMIT_W-1:0] raw_limit;
		logic [MV_W-1:0]    spread_limit_mv;
	} cfg_t;

	// one classified sample waiting for the back end
	typedef struct packed {
		logic [RAW_W-1:0] raw_code;
		logic [MV_W-1:0]  sample_mv;
		logic             last_sample;
		class_t           band;
		logic             raw_bad;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[src/fsbc_front.sv]
`timescale 1ns / 1ps
// fsbc_front: accepts samples and tags them with band and raw-code check
// depends on fsbc_pkg
module fsbc_front (
	input  logic                            sample_valid,
	output logic                            sample_ready,
	input  logic [fsbc_pkg::RAW_W-1:0]      raw_code,
	input  logic [fsbc_pkg::MV_W-1:0]       sample_mv,
	input  logic                            last_sample,
	input  fsbc_pkg::cfg_t                  cfg,
	input  fsbc_pkg::q_status_t             q_status,
	output logic                            push,
	output fsbc_pkg::entry_t                push_entry
);

	fsbc_pkg::class_t band;

	// window compares, band a first, then band b, then missing
	always_comb begin
		if (sample_mv >= cfg.band_a_min_mv && sample_mv <= cfg.band_a_max_mv) begin
			band = fsbc_pkg::CLASS_A;
		end else if (sample_mv >= cfg.band_b_min_mv && sample_mv <= cfg.band_b_max_mv) begin
			band = fsbc_pkg::CLASS_B;
		end else if (sample_mv >= cfg.missing_min_mv) begin
			band = fsbc_pkg::CLASS_MISSING;
		end else begin
			band = fsbc_pkg::CLASS_INVALID;
		end
	end

	assign sample_ready = !q_status.full;
	assign push         = sample_valid && sample_ready;

	always_comb begin
		push_entry.raw_code    = raw_code;
		push_entry.sample_mv   = sample_mv;
		push_entry.last_sample = last_sample;
		push_entry.band        = band;
		push_entry.raw_bad     = (raw_code == '0) ||
			({1'b0, raw_code} >= cfg.raw_limit);
	end

endmodule

[src/fsbc_queue.sv]
`timescale 1ns / 1ps
// fsbc_queue: short fifo of classified samples between front and back
// depends on fsbc_pkg
module fsbc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  fsbc_pkg::entry_t     push_entry,
	input  logic                 pop,
	output fsbc_pkg::entry_t     head,
	output fsbc_pkg::q_status_t  status
);

	localparam logic [fsbc_pkg::QPTR_W-1:0] PTR_LAST = fsbc_pkg::QPTR_W'(fsbc_pkg::QUEUE_DEPTH - 1);
	localparam logic [fsbc_pkg::QCNT_W-1:0] CNT_FULL = fsbc_pkg::QCNT_W'(fsbc_pkg::QUEUE_DEPTH);

	fsbc_pkg::entry_t               slot_q [fsbc_pkg::QUEUE_DEPTH];
	logic [fsbc_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [fsbc_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [fsbc_pkg::QCNT_W-1:0]    count_q;
	logic                           do_push;
	logic                           do_pop;

	assign status.full  = (count_q == CNT_FULL);
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/fsbc_back.sv]
`timescale 1ns / 1ps
// fsbc_back: batch accumulator and result register
// depends on fsbc_pkg
module fsbc_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fsbc_pkg::entry_t                 head,
	input  fsbc_pkg::q_status_t              q_status,
	output logic                             pop,
	input  logic [fsbc_pkg::MV_W-1:0]        spread_limit_mv,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic [1:0]                       class_code,
	output logic [fsbc_pkg::COUNT_W-1:0]     batch_count,
	output logic [fsbc_pkg::RAW_W-1:0]       raw_average,
	output logic [fsbc_pkg::MV_W-1:0]        mv_mean,
	output logic [fsbc_pkg::MV_W-1:0]        mv_lowest,
	output logic [fsbc_pkg::MV_W-1:0]        mv_highest,
	output logic [fsbc_pkg::MV_W-1:0]        mv_range
);

	localparam logic [fsbc_pkg::COUNT_W-1:0] COUNT_OK = fsbc_pkg::COUNT_W'(fsbc_pkg::SAMPLES);

	// batch state
	logic [fsbc_pkg::COUNT_W-1:0] seen_q;
	logic [fsbc_pkg::SUM_W-1:0]   raw_total_q;
	logic [fsbc_pkg::SUM_W-1:0]   mv_total_q;
	logic [fsbc_pkg::MV_W-1:0]    low_q;
	logic [fsbc_pkg::MV_W-1:0]    high_q;
	fsbc_pkg::class_t             first_band_q;
	logic                         good_q;

	// state after this sample
	logic [fsbc_pkg::COUNT_W-1:0] seen_n;
	logic [fsbc_pkg::SUM_W-1:0]   raw_total_n;
	logic [fsbc_pkg::SUM_W-1:0]   mv_total_n;
	logic [fsbc_pkg::MV_W-1:0]    low_n;
	logic [fsbc_pkg::MV_W-1:0]    high_n;
	fsbc_pkg::class_t             first_band_n;
	logic                         good_n;
	logic                         first;
	logic [fsbc_pkg::MV_W-1:0]    spread_n;
	logic                         len_ok;
	fsbc_pkg::class_t             class_n;

	logic                         out_valid_q;
	logic                         out_free;

	assign out_free = !out_valid_q || result_ready;
	assign pop      = !q_status.empty && (!head.last_sample || out_free);

	always_comb begin
		first        = (seen_q == '0);
		seen_n       = (seen_q == fsbc_pkg::COUNT_MAX) ? seen_q : seen_q + 1'b1;
		raw_total_n  = raw_total_q + fsbc_pkg::SUM_W'(head.raw_code);
		mv_total_n   = mv_total_q + fsbc_pkg::SUM_W'(head.sample_mv);
		low_n        = (first || head.sample_mv < low_q) ? head.sample_mv : low_q;
		high_n       = (first || head.sample_mv > high_q) ? head.sample_mv : high_q;
		first_band_n = first ? head.band : first_band_q;
		good_n       = (first ? (head.band != fsbc_pkg::CLASS_INVALID) : good_q) &&
			!head.raw_bad && (head.band == first_band_n);
		spread_n     = high_n - low_n;
		len_ok       = (seen_n == COUNT_OK);
		class_n      = (good_n && spread_n <= spread_limit_mv) ?
			first_band_n : fsbc_pkg::CLASS_INVALID;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= '0;
			raw_total_q  <= '0;
			mv_total_q   <= '0;
			low_q        <= '0;
			high_q       <= '0;
			first_band_q <= fsbc_pkg::CLASS_INVALID;
			good_q       <= 1'b1;
		end else if (pop) begin
			if (head.last_sample) begin
				seen_q       <= '0;
				raw_total_q  <= '0;
				mv_total_q   <= '0;
				low_q        <= '0;
				high_q       <= '0;
				first_band_q <= fsbc_pkg::CLASS_INVALID;
				good_q       <= 1'b1;
			end else begin
				seen_q       <= seen_n;
				raw_total_q  <= raw_total_n;
				mv_total_q   <= mv_total_n;
				low_q        <= low_n;
				high_q       <= high_n;
				first_band_q <= first_band_n;
				good_q       <= good_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.last_sample) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, zeroed when the batch length was wrong
	always_ff @(posedge clk) begin
		if (pop && head.last_sample) begin
			if (len_ok) begin
				class_code  <= class_n;
				batch_count <= COUNT_OK;
				raw_average <= fsbc_pkg::RAW_W'(raw_total_n / fsbc_pkg::SAMPLES);
				mv_mean     <= fsbc_pkg::MV_W'(mv_total_n / fsbc_pkg::SAMPLES);
				mv_lowest   <= low_n;
				mv_highest  <= high_n;
				mv_range    <= spread_n;
			end else begin
				class_code  <= fsbc_pkg::CLASS_INVALID;
				batch_count <= '0;
				raw_average <= '0;
				mv_mean     <= '0;
				mv_lowest   <= '0;
				mv_highest  <= '0;
				mv_range    <= '0;
			end
		end
	end

	assign result_valid = out_valid_q;

endmodule

[src/filter_sense_batch_classifier_top.sv]
`timescale 1ns / 1ps
// filter_sense_batch_classifier_top: register file, front, queue and back
// depends on fsbc_pkg, fsbc_front, fsbc_queue, fsbc_back
//
// usage
// - sample channel: sample_valid/sample_ready with raw_code, sample_mv and
//   last_sample; one transaction carries one sensed sample
// - result channel: result_valid/result_ready; one transaction per batch,
//   sent for the sample that has last_sample set
// - apb port: seven registers in 32-bit words at byte offsets 0x00..0x18, write
//   only while no batch is in flight; pready is tied high
// - throughput: one sample per cycle while the queue has room; the front
//   classifies a sample in the cycle it is taken; the back folds one queued
//   sample per cycle, but waits on a last sample while a result is unread
// - result path: a taken sample is written into the queue; the back folds it
//   from the queue head into the result register, after earlier queued samples
// - receiver stall: the result register holds; the back keeps folding
//   samples of the next batch and only waits when a second last sample is
//   ready; the four-entry queue then fills and sample_ready drops
// - reset: registers return to their reset values, the queue empties,
//   batch state clears and no result is pending
module filter_sense_batch_classifier_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// apb configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fsbc_pkg::PADDR_W-1:0]    paddr,
	input  logic [fsbc_pkg::PDATA_W-1:0]    pwdata,
	output logic [fsbc_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready,
	// samples
	input  logic                            sample_valid,
	output logic                            sample_ready,
	input  logic [fsbc_pkg::RAW_W-1:0]      raw_code,
	input  logic [fsbc_pkg::MV_W-1:0]       sample_mv,
	input  logic                            last_sample,
	// results
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [1:0]                      class_code,
	output logic [fsbc_pkg::COUNT_W-1:0]    batch_count,
	output logic [fsbc_pkg::RAW_W-1:0]      raw_average,
	output logic [fsbc_pkg::MV_W-1:0]       mv_mean,
	output logic [fsbc_pkg::MV_W-1:0]       mv_lowest,
	output logic [fsbc_pkg::MV_W-1:0]       mv_highest,
	output logic [fsbc_pkg::MV_W-1:0]       mv_range
);

	fsbc_pkg::cfg_t       cfg_q;
	fsbc_pkg::reg_idx_t   reg_idx;
	logic                 cfg_write;
	fsbc_pkg::q_status_t  q_status;
	fsbc_pkg::entry_t     push_entry;
	fsbc_pkg::entry_t     head;
	logic                 push;
	logic                 pop;

	// register decode: word index from the byte address
	assign reg_idx   = fsbc_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_a_min_mv   <= '0;
			cfg_q.band_a_max_mv   <= '0;
			cfg_q.band_b_min_mv   <= '0;
			cfg_q.band_b_max_mv   <= '0;
			cfg_q.missing_min_mv  <= '1;
			cfg_q.raw_limit       <= fsbc_pkg::LIMIT_W'(4095);
			cfg_q.spread_limit_mv <= '0;
		end else if (cfg_write) begin
			case (reg_idx)
				fsbc_pkg::REG_BAND_A_MIN:  cfg_q.band_a_min_mv   <= pwdata[11:0];
				fsbc_pkg::REG_BAND_A_MAX:  cfg_q.band_a_max_mv   <= pwdata[11:0];
				fsbc_pkg::REG_BAND_B_MIN:  cfg_q.band_b_min_mv   <= pwdata[11:0];
				fsbc_pkg::REG_BAND_B_MAX:  cfg_q.band_b_max_mv   <= pwdata[11:0];
				fsbc_pkg::REG_MISSING_MIN: cfg_q.missing_min_mv  <= pwdata[11:0];
				fsbc_pkg::REG_RAW_LIMIT:   cfg_q.raw_limit       <= pwdata[12:0];
				fsbc_pkg::REG_SPREAD_LIM:  cfg_q.spread_limit_mv <= pwdata[11:0];
				// offsets past the last register are ignored
				default: begin
				end
			endcase
		end
	end

	// read-back mux, zero beyond the register list
	always_comb begin
		case (reg_idx)
			fsbc_pkg::REG_BAND_A_MIN:  prdata = fsbc_pkg::PDATA_W'(cfg_q.band_a_min_mv);
			fsbc_pkg::REG_BAND_A_MAX:  prdata = fsbc_pkg::PDATA_W'(cfg_q.band_a_max_mv);
			fsbc_pkg::REG_BAND_B_MIN:  prdata = fsbc_pkg::PDATA_W'(cfg_q.band_b_min_mv);
			fsbc_pkg::REG_BAND_B_MAX:  prdata = fsbc_pkg::PDATA_W'(cfg_q.band_b_max_mv);
			fsbc_pkg::REG_MISSING_MIN: prdata = fsbc_pkg::PDATA_W'(cfg_q.missing_min_mv);
			fsbc_pkg::REG_RAW_LIMIT:   prdata = fsbc_pkg::PDATA_W'(cfg_q.raw_limit);
			fsbc_pkg::REG_SPREAD_LIM:  prdata = fsbc_pkg::PDATA_W'(cfg_q.spread_limit_mv);
			default:                   prdata = '0;
		endcase
	end

	// front: take a sample, find its band, check the raw code
	fsbc_front u_front (
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.raw_code     (raw_code),
		.sample_mv    (sample_mv),
		.last_sample  (last_sample),
		.cfg          (cfg_q),
		.q_status     (q_status),
		.push         (push),
		.push_entry   (push_entry)
	);

	// decoupling queue
	fsbc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	// back: running sums, min and max, batch verdict
	fsbc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.q_status        (q_status),
		.pop             (pop),
		.spread_limit_mv (cfg_q.spread_limit_mv),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.class_code      (class_code),
		.batch_count     (batch_count),
		.raw_average     (raw_average),
		.mv_mean         (mv_mean),
		.mv_lowest       (mv_lowest),
		.mv_highest      (mv_highest),
		.mv_range        (mv_range)
	);

`ifndef SYNTHESIS
	// queue status is never full and empty at once
	assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue reports full and empty together");

	// a valid class only comes with a batch of the right length
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (class_code != fsbc_pkg::CLASS_INVALID) |->
			batch_count == fsbc_pkg::COUNT_W'(fsbc_pkg::SAMPLES))
		else $error("valid class on a wrong-length batch");

	// a wrong-length batch reports all zeros
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (batch_count == '0) |->
			(class_code == fsbc_pkg::CLASS_INVALID) && (raw_average == '0) &&
			(mv_mean == '0) && (mv_lowest == '0) && (mv_highest == '0))
		else $error("wrong-length batch with nonzero fields");

	// spread matches the reported extremes
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (mv_range == mv_highest - mv_lowest) &&
			(mv_lowest <= mv_highest))
		else $error("spread inconsistent with min and max");
`endif

endmodule

[sim/fsbc_batch_checker.sv]
`timescale 1ns / 1ps
// fsbc_batch_checker: watches the apb, sample and result channels of the batch
// classifier, predicts each batch summary and compares it field by field
// depends on fsbc_pkg
module fsbc_batch_checker
	import fsbc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               sample_valid,
	input  logic               sample_ready,
	input  logic [RAW_W-1:0]   raw_code,
	input  logic [MV_W-1:0]    sample_mv,
	input  logic               last_sample,
	input  logic               result_valid,
	input  logic               result_ready,
	input  logic [1:0]         class_code,
	input  logic [COUNT_W-1:0] batch_count,
	input  logic [RAW_W-1:0]   raw_average,
	input  logic [MV_W-1:0]    mv_mean,
	input  logic [MV_W-1:0]    mv_lowest,
	input  logic [MV_W-1:0]    mv_highest,
	input  logic [MV_W-1:0]    mv_range,
	output int                 fail_count,
	output int                 pending,
	output int                 samples_taken,
	output int                 summary_count,
	output int                 classified_count
);

	typedef struct packed {
		class_t             cls;
		logic [COUNT_W-1:0] count;
		logic [RAW_W-1:0]   raw_avg;
		logic [MV_W-1:0]    mv_avg;
		logic [MV_W-1:0]    low;
		logic [MV_W-1:0]    high;
		logic [MV_W-1:0]    width;
	} batch_summary_t;

	cfg_t               cfg;
	logic [COUNT_W-1:0] seen;
	logic [SUM_W-1:0]   raw_sum;
	logic [SUM_W-1:0]   mv_sum;
	logic [MV_W-1:0]    low_mv;
	logic [MV_W-1:0]    high_mv;
	class_t             lead_band;
	logic               clean;
	batch_summary_t     summaries_due[$];

	function automatic void clear_batch();
		seen = '0;
		raw_sum = '0;
		mv_sum = '0;
		low_mv = '0;
		high_mv = '0;
		lead_band = CLASS_INVALID;
		clean = 1'b1;
	endfunction

	// window compares in priority order: a, then b, then missing
	function automatic class_t band_of_mv(input logic [MV_W-1:0] mv);
		if (mv >= cfg.band_a_min_mv && mv <= cfg.band_a_max_mv)
			return CLASS_A;
		if (mv >= cfg.band_b_min_mv && mv <= cfg.band_b_max_mv)
			return CLASS_B;
		if (mv >= cfg.missing_min_mv)
			return CLASS_MISSING;
		return CLASS_INVALID;
	endfunction

	function automatic void write_cfg(input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] data);
		case (addr[4:2])
			REG_BAND_A_MIN:  cfg.band_a_min_mv = data[MV_W-1:0];
			REG_BAND_A_MAX:  cfg.band_a_max_mv = data[MV_W-1:0];
			REG_BAND_B_MIN:  cfg.band_b_min_mv = data[MV_W-1:0];
			REG_BAND_B_MAX:  cfg.band_b_max_mv = data[MV_W-1:0];
			REG_MISSING_MIN: cfg.missing_min_mv = data[MV_W-1:0];
			REG_RAW_LIMIT:   cfg.raw_limit = data[LIMIT_W-1:0];
			REG_SPREAD_LIM:  cfg.spread_limit_mv = data[MV_W-1:0];
			default: ;
		endcase
	endfunction

	// folds one sample into the batch; returns 1 when it closes the batch
	function automatic bit fold_sample(input logic [RAW_W-1:0] raw,
			input logic [MV_W-1:0] mv, input logic last, output batch_summary_t s);
		class_t band;
		logic [MV_W-1:0] width;
		band = band_of_mv(mv);
		s = '0;
		if (seen == '0) begin
			low_mv = mv;
			high_mv = mv;
			lead_band = band;
			clean = (band != CLASS_INVALID);
		end
		raw_sum = raw_sum + SUM_W'(raw);
		mv_sum = mv_sum + SUM_W'(mv);
		if (mv < low_mv)
			low_mv = mv;
		if (mv > high_mv)
			high_mv = mv;
		if (raw == '0 || {1'b0, raw} >= cfg.raw_limit || band != lead_band)
			clean = 1'b0;
		if (seen != COUNT_MAX)
			seen = seen + 1'b1;
		if (!last)
			return 1'b0;
		// wrong length leaves the summary all zero
		if (seen == COUNT_W'(SAMPLES)) begin
			width = high_mv - low_mv;
			s.cls = (clean && width <= cfg.spread_limit_mv) ? lead_band : CLASS_INVALID;
			s.count = COUNT_W'(SAMPLES);
			s.raw_avg = RAW_W'(raw_sum / SUM_W'(SAMPLES));
			s.mv_avg = MV_W'(mv_sum / SUM_W'(SAMPLES));
			s.low = low_mv;
			s.high = high_mv;
			s.width = width;
		end
		clear_batch();
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		batch_summary_t want;
		if (!arst_n) begin
			cfg.band_a_min_mv = '0;
			cfg.band_a_max_mv = '0;
			cfg.band_b_min_mv = '0;
			cfg.band_b_max_mv = '0;
			cfg.missing_min_mv = MV_W'(4095);
			cfg.raw_limit = LIMIT_W'(4095);
			cfg.spread_limit_mv = '0;
			clear_batch();
			summaries_due.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready)
				write_cfg(paddr, pwdata);
			if (sample_valid && sample_ready) begin
				samples_taken++;
				if (fold_sample(raw_code, sample_mv, last_sample, want))
					summaries_due.push_back(want);
			end
			if (result_valid && result_ready) begin
				if (summaries_due.size() == 0) begin
					$error("result transaction with no batch summary pending");
					fail_count++;
				end else begin
					want = summaries_due.pop_front();
					summary_count++;
					if (want.cls != CLASS_INVALID)
						classified_count++;
					check_field("class_code", want.cls, class_code);
					check_field("batch_count", want.count, batch_count);
					check_field("raw_average", want.raw_avg, raw_average);
					check_field("mv_mean", want.mv_avg, mv_mean);
					check_field("mv_lowest", want.low, mv_lowest);
					check_field("mv_highest", want.high, mv_highest);
					check_field("mv_range", want.width, mv_range);
				end
			end
			pending = summaries_due.size();
		end
	end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: stimulus, idling and verdict for the filter sense batch classifier
// depends on fsbc_pkg, filter_sense_batch_classifier_top and fsbc_batch_checker
module tb_top;
	import fsbc_pkg::*;

	// address slot past the last register, writes there must be ignored
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int unsigned PHASES = 12;
	localparam int unsigned PHASE_SAMPLES = 110;
	localparam int unsigned LONG_HOLD = 400;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               sample_valid;
	logic               sample_ready;
	logic [RAW_W-1:0]   raw_code;
	logic [MV_W-1:0]    sample_mv;
	logic               last_sample;
	logic               result_valid;
	logic               result_ready;
	logic [1:0]         class_code;
	logic [COUNT_W-1:0] batch_count;
	logic [RAW_W-1:0]   raw_average;
	logic [MV_W-1:0]    mv_mean;
	logic [MV_W-1:0]    mv_lowest;
	logic [MV_W-1:0]    mv_highest;
	logic [MV_W-1:0]    mv_range;

	int fail_count;
	int pending;
	int samples_taken;
	int summary_count;
	int classified_count;

	// stimulus copy of the current windows, only used to aim the samples
	int unsigned a_lo, a_hi, b_lo, b_hi, miss_lo, rlim, slim;
	int unsigned settings_applied;
	// asks the result side for one long stall
	bit long_hold_req;

	filter_sense_batch_classifier_top dut (.*);

	fsbc_batch_checker checker_i (.*);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// mostly back to back, sometimes a few cycles, rarely a long pause
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// apb write: setup cycle, then access cycle until pready
	task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		// junk in the upper half must be dropped by the register
		pwdata <= value | {16'($urandom()), 16'h0000};
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_settings(input int unsigned al, input int unsigned ah,
			input int unsigned bl, input int unsigned bh, input int unsigned ml,
			input int unsigned rl, input int unsigned sl);
		a_lo = al;
		a_hi = ah;
		b_lo = bl;
		b_hi = bh;
		miss_lo = ml;
		rlim = rl;
		slim = sl;
		write_reg(REG_BAND_A_MIN, al);
		write_reg(REG_BAND_A_MAX, ah);
		write_reg(REG_BAND_B_MIN, bl);
		write_reg(REG_BAND_B_MAX, bh);
		write_reg(REG_MISSING_MIN, ml);
		write_reg(REG_RAW_LIMIT, rl);
		write_reg(REG_SPREAD_LIM, sl);
		write_reg(REG_UNUSED, $urandom());
		settings_applied++;
	endtask

	// one sample transaction; valid stays up until taken, then an optional gap
	task automatic send_sample(input logic [RAW_W-1:0] raw, input logic [MV_W-1:0] mv,
			input logic last, input bit calm);
		int unsigned gap;
		@(negedge clk);
		sample_valid <= 1'b1;
		raw_code <= raw;
		sample_mv <= mv;
		last_sample <= last;
		do begin
			@(posedge clk);
		end while (!sample_ready);
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			sample_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// a batch aimed at one window with a jitter that is mostly narrow, so that good batches
	// are common; raw codes now and then hit zero or the top code 4095
	task automatic send_batch(input int unsigned len);
		int unsigned lo, hi, base, jit, mv, raw, raw_hi, i;
		bit calm;
		calm = ($urandom_range(0, 3) == 0);
		case ($urandom_range(0, 3))
			0: begin
				lo = a_lo;
				hi = a_hi;
			end
			1: begin
				lo = b_lo;
				hi = b_hi;
			end
			2: begin
				lo = miss_lo;
				hi = 4095;
			end
			default: begin
				lo = 0;
				hi = 4095;
			end
		endcase
		if (lo > hi) begin
			lo = 0;
			hi = 4095;
		end
		base = $urandom_range(lo, hi);
		jit = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, slim);
		raw_hi = (rlim == 0) ? 0 : rlim - 1;
		for (i = 0; i < len; i++) begin
			mv = base + $urandom_range(0, jit);
			if (mv > hi && $urandom_range(0, 7) != 0)
				mv = hi;
			if (mv > 4095)
				mv = 4095;
			case ($urandom_range(0, 19))
				0: raw = 0;
				1: raw = 4095;
				2: raw = $urandom_range(0, 4095);
				default: raw = (raw_hi >= 1) ? $urandom_range(1, raw_hi) : $urandom_range(0, 4095);
			endcase
			send_sample(raw[RAW_W-1:0], mv[MV_W-1:0], i == len - 1, calm);
		end
	endtask

	// drop valid, wait for every summary, then let the pipe run dry
	task automatic settle();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// result side: random stalls, calm stretches, and one long hold-off on request
	initial begin : result_sink
		int unsigned hold;
		int unsigned stretch;
		bit calm;
		bit long_hold_done;
		hold = 0;
		stretch = 0;
		calm = 1'b0;
		long_hold_done = 1'b0;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req && !long_hold_done) begin
				hold = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (stretch == 0) begin
				stretch = $urandom_range(50, 300);
				calm = ($urandom_range(0, 3) == 0);
			end
			stretch--;
			if (hold > 0) begin
				result_ready <= 1'b0;
				hold--;
			end else begin
				result_ready <= 1'b1;
				if (!calm)
					hold = pick_gap();
			end
		end
	end

	initial begin : stimulus
		int unsigned phase, sent, len, al, bl;
		// every block input known from time zero
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_valid = 1'b0;
		raw_code = '0;
		sample_mv = '0;
		last_sample = 1'b0;
		long_hold_req = 1'b0;
		settings_applied = 1;
		// reset values of the registers
		a_lo = 0;
		a_hi = 0;
		b_lo = 0;
		b_hi = 0;
		miss_lo = 4095;
		rlim = 4095;
		slim = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed, reset settings: a full batch at 0 mV lands in band a with
		// raw codes just inside both ends of the good range
		send_sample(12'd1, 12'd0, 1'b0, 1'b1);
		send_sample(12'd4094, 12'd0, 1'b0, 1'b0);
		send_sample(12'h555, 12'd0, 1'b0, 1'b0);
		send_sample(12'hAAA, 12'd0, 1'b0, 1'b1);
		repeat (11) send_sample(12'($urandom_range(1, 4094)), 12'd0, 1'b0, 1'b0);
		send_sample(12'd2048, 12'd0, 1'b1, 1'b0);
		// short batches: one sample, then two, both with the wrong length
		send_sample(12'd0, 12'd4095, 1'b1, 1'b0);
		send_sample(12'd4095, 12'd4095, 1'b0, 1'b0);
		send_sample(12'd4095, 12'hAAA, 1'b1, 1'b1);
		settle();

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				// overlapping windows: a wins over b, b over missing
				0: apply_settings(1000, 2000, 1500, 2500, 1800, 4095, 200);
				// inverted a and b windows match nothing; only missing can match
				1: apply_settings(3000, 1000, 2000, 500, 3500, 2048, 100);
				// raw limit of zero, every sample bad
				2: apply_settings(0, 2047, 2048, 4095, 4095, 0, 4095);
				// top extremes
				3: apply_settings(4095, 4095, 4095, 4095, 4095, 4096, 4095);
				// bottom extremes, everything above 0 mV counts as missing
				4: apply_settings(0, 0, 0, 0, 0, 4096, 0);
				default: begin
					al = $urandom_range(0, 4095);
					bl = $urandom_range(0, 4095);
					apply_settings(al, (al + $urandom_range(0, 800)) % 4096,
						bl, (bl + $urandom_range(0, 800)) % 4096,
						$urandom_range(2048, 4095), $urandom_range(1500, 4096),
						$urandom_range(0, 400));
				end
			endcase
			// one phase runs under a long receiver stall so the queue fills
			if (phase == 5)
				long_hold_req = 1'b1;
			// one batch long enough to saturate the sample counter
			if (phase == 7)
				send_batch(515);
			sent = 0;
			while (sent < PHASE_SAMPLES) begin
				if ($urandom_range(0, 9) < 8)
					len = SAMPLES;
				else if ($urandom_range(0, 1) == 0)
					len = $urandom_range(1, SAMPLES - 1);
				else
					len = $urandom_range(SAMPLES + 1, 40);
				send_batch(len);
				sent += len;
			end
			settle();
		end

		$display("run covered %0d samples and %0d batch summaries (%0d classified)",
			samples_taken, summary_count, classified_count);
		$display("over %0d register settings, with short and overlong batches,",
			settings_applied);
		$display("a saturated count, a long result stall and random idling");
		if (fail_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin : watchdog
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
